@@ hdl/kat_pkg.sv @@
// Shared types and constants of the key-to-action state tracker.
package kat_pkg;

    // Default sizes of the binding table
    localparam int DEF_MAX_ACTIONS     = 16;
    localparam int DEF_KEYS_PER_ACTION = 4;
    localparam int DEF_KEY_CODE_BITS   = 9;

    // Field widths of the stream payloads
    localparam int KIND_W = 3;
    localparam int KEY_W  = 9;
    localparam int ACT_W  = 4;
    localparam int MASK_W = 16;

    // Input transaction kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BIND    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd4;

    // Operations of the row update unit
    typedef enum logic [1:0] {
        ROP_BIND    = 2'd0,
        ROP_PRESS   = 2'd1,
        ROP_RELEASE = 2'd2,
        ROP_TICK    = 2'd3
    } t_row_op;

    // Row status reported back to the sequencer
    typedef struct packed {
        logic hit;          // some in-use slot holds the key
        logic held_any;     // OR of the updated held flags
        logic pressed_any;  // OR of the updated pressed flags
        logic full;         // every slot of the row is in use
    } t_row_stat;

endpackage

@@ hdl/kat_row_mem.sv @@
// Binding table memory: one row per action, registered read.
module kat_row_mem #(
    parameter int DW    = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one row, data valid the next cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/kat_row_unit.sv @@
// Row update unit: compares the key against every slot of one row and updates its flags.
module kat_row_unit #(
    parameter int KEYS_PER_ACTION = 4,
    parameter int KB              = 9,
    parameter int CB              = 3
) (
    input  logic [KEYS_PER_ACTION*(KB+2)+CB-1:0] i_row,
    input  logic [CB-1:0]                        i_count,
    input  logic [KB-1:0]                        i_key,
    input  kat_pkg::t_row_op                     i_op,
    output logic [KEYS_PER_ACTION*(KB+2)+CB-1:0] o_row,
    output kat_pkg::t_row_stat                   o_stat
);

    localparam int SW = KB + 2;
    localparam int K  = KEYS_PER_ACTION;

    always_comb begin
        logic          in_use;
        logic          match;
        logic [SW-1:0] slot;
        o_row               = i_row;
        o_stat.hit          = 1'b0;
        o_stat.held_any     = 1'b0;
        o_stat.pressed_any  = 1'b0;
        o_stat.full         = (i_count >= CB'(K));
        // Count field: advance on an append, keep otherwise
        if (i_op == kat_pkg::ROP_BIND) begin
            o_row[K*SW +: CB] = i_count + CB'(1);
        end else begin
            o_row[K*SW +: CB] = i_count;
        end
        // Update each slot on its own
        for (int s = 0; s < K; s++) begin
            slot   = i_row[s*SW +: SW];
            in_use = (CB'(s) < i_count);
            match  = in_use && (slot[KB-1:0] == i_key);
            unique case (i_op)
                kat_pkg::ROP_BIND: begin
                    if (CB'(s) == i_count) begin
                        slot = {2'b00, i_key};
                    end
                end
                kat_pkg::ROP_PRESS: begin
                    if (match) begin
                        slot[KB]   = 1'b1;
                        slot[KB+1] = 1'b1;
                    end
                end
                kat_pkg::ROP_RELEASE: begin
                    if (match) begin
                        slot[KB]   = 1'b0;
                        slot[KB+1] = 1'b0;
                    end
                end
                kat_pkg::ROP_TICK: begin
                    slot[KB+1] = 1'b0;
                end
                default: begin
                end
            endcase
            o_row[s*SW +: SW] = slot;
            o_stat.hit         = o_stat.hit | match;
            o_stat.held_any    = o_stat.held_any | (in_use & slot[KB]);
            o_stat.pressed_any = o_stat.pressed_any | (in_use & slot[KB+1]);
        end
    end

endmodule

@@ hdl/key_to_action_state_tracker_unit.sv @@
// Top level of the key-to-action state tracker: sequencer, action flags and stream ports.
//
// Maps raw key transactions onto logical actions and returns the held and pressed
// masks of actions 0..15 for every input transaction, bind_error in tuser. The binding
// table sits in a memory with one row per action (slot count and every slot's key,
// held and pressed flags), read and written back through separate row ports by one
// shared row update unit. A press, release or frame tick walks all rows, one per cycle,
// and then gives its result; a bind reads and updates its own row and then gives its
// result; a clear and an unused kind give theirs without a row access. The input is
// ready again in the cycle after the result is loaded. It takes a new transaction
// only while the sequencer is idle, and a finished result waits in the output
// register without holding up the next input. Reset and clear take effect at once
// through per-row valid bits, with no sweep of the memory.
module key_to_action_state_tracker_unit #(
    parameter int MAX_ACTIONS     = kat_pkg::DEF_MAX_ACTIONS,
    parameter int KEYS_PER_ACTION = kat_pkg::DEF_KEYS_PER_ACTION,
    parameter int KEY_CODE_BITS   = kat_pkg::DEF_KEY_CODE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // key_code[8:0], action_id[12:9], zeros[15:13]
    input  logic [2:0]  i_s_axis_tuser,   // kind[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // held_mask[15:0], pressed_mask[31:16]
    output logic [0:0]  o_m_axis_tuser    // bind_error[0]
);

    localparam int KB = (KEY_CODE_BITS < kat_pkg::KEY_W) ? KEY_CODE_BITS : kat_pkg::KEY_W;
    localparam int SW = KB + 2;
    localparam int CB = $clog2(KEYS_PER_ACTION + 1);
    localparam int RW = KEYS_PER_ACTION * SW + CB;
    localparam int AW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int MW = kat_pkg::MASK_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_BIND  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic [kat_pkg::KIND_W-1:0] r_kind;
    logic [KB-1:0]             r_key;
    logic [kat_pkg::ACT_W-1:0] r_act;
    logic [AW-1:0]             r_idx;
    logic                      r_err;
    logic [MAX_ACTIONS-1:0]    r_row_vld;
    logic [MAX_ACTIONS-1:0]    r_act_held;
    logic [MAX_ACTIONS-1:0]    r_act_pressed;
    logic                      r_out_vld;
    logic [MW-1:0]             r_out_held;
    logic [MW-1:0]             r_out_pressed;
    logic                      r_out_err;

    logic                      accept;
    logic                      load;
    logic                      last_row;
    logic                      bind_ok;
    logic [kat_pkg::KIND_W-1:0] in_kind;
    logic [kat_pkg::ACT_W-1:0] in_act;
    logic [AW+kat_pkg::ACT_W-1:0] in_act_ext;
    logic [AW+kat_pkg::ACT_W-1:0] r_act_ext;
    logic [AW-1:0]             in_act_addr;
    logic [AW-1:0]             act_addr;
    logic [AW-1:0]             cur_addr;
    logic [AW-1:0]             rd_addr;
    logic [RW-1:0]             rd_row;
    logic [RW-1:0]             new_row;
    logic [CB-1:0]             cur_count;
    logic                      cur_vld;
    logic                      mem_we;
    kat_pkg::t_row_op          row_op;
    kat_pkg::t_row_stat        row_stat;
    logic [MAX_ACTIONS+MW-1:0] held_ext;
    logic [MAX_ACTIONS+MW-1:0] pressed_ext;

    // Decode the input transaction
    assign in_kind     = i_s_axis_tuser;
    assign in_act      = i_s_axis_tdata[kat_pkg::KEY_W +: kat_pkg::ACT_W];
    assign in_act_ext  = {{AW{1'b0}}, in_act};
    assign in_act_addr = in_act_ext[AW-1:0];
    assign r_act_ext   = {{AW{1'b0}}, r_act};
    assign act_addr    = r_act_ext[AW-1:0];
    assign bind_ok     = (32'(in_act) < 32'(MAX_ACTIONS));

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign load            = (r_state == S_DONE) && (!r_out_vld || i_m_axis_tready);
    assign last_row        = (r_idx == AW'(MAX_ACTIONS - 1));

    // Select the row being read and the row being updated
    always_comb begin
        cur_addr = (r_state == S_BIND) ? act_addr : r_idx;
        if (r_state == S_IDLE) begin
            rd_addr = (in_kind == kat_pkg::KIND_BIND) ? in_act_addr : '0;
        end else if (r_state == S_SWEEP) begin
            rd_addr = r_idx + AW'(1);
        end else begin
            rd_addr = r_idx;
        end
    end

    assign cur_vld   = r_row_vld[cur_addr];
    assign cur_count = cur_vld ? rd_row[KEYS_PER_ACTION*SW +: CB] : '0;

    // Pick the row operation from the stored kind
    always_comb begin
        unique case (r_kind)
            kat_pkg::KIND_BIND:    row_op = kat_pkg::ROP_BIND;
            kat_pkg::KIND_PRESS:   row_op = kat_pkg::ROP_PRESS;
            kat_pkg::KIND_RELEASE: row_op = kat_pkg::ROP_RELEASE;
            default:               row_op = kat_pkg::ROP_TICK;
        endcase
    end

    assign mem_we = ((r_state == S_BIND) && !row_stat.full) ||
                    ((r_state == S_SWEEP) && cur_vld);

    kat_row_mem #(
        .DW    (RW),
        .DEPTH (MAX_ACTIONS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (cur_addr),
        .i_wdata (new_row),
        .i_raddr (rd_addr),
        .o_rdata (rd_row)
    );

    kat_row_unit #(
        .KEYS_PER_ACTION (KEYS_PER_ACTION),
        .KB              (KB),
        .CB              (CB)
    ) u_row (
        .i_row   (rd_row),
        .i_count (cur_count),
        .i_key   (r_key),
        .i_op    (row_op),
        .o_row   (new_row),
        .o_stat  (row_stat)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_kind) inside
                        kat_pkg::KIND_BIND: n_state = bind_ok ? S_BIND : S_DONE;
                        kat_pkg::KIND_PRESS, kat_pkg::KIND_RELEASE,
                        kat_pkg::KIND_TICK: n_state = S_SWEEP;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_BIND: begin
                n_state = S_DONE;
            end
            S_SWEEP: begin
                if (last_row) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the transaction, walk the rows and update the action flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_err         <= 1'b0;
            r_row_vld     <= '0;
            r_act_held    <= '0;
            r_act_pressed <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= in_kind;
                        r_key  <= i_s_axis_tdata[KB-1:0];
                        r_act  <= in_act;
                        r_idx  <= '0;
                        r_err  <= 1'b0;
                        if (in_kind == kat_pkg::KIND_CLEAR) begin
                            r_row_vld     <= '0;
                            r_act_held    <= '0;
                            r_act_pressed <= '0;
                        end
                        if (in_kind == kat_pkg::KIND_TICK) begin
                            r_act_pressed <= '0;
                        end
                    end
                end
                S_BIND: begin
                    if (row_stat.full) begin
                        r_err <= 1'b1;
                    end else begin
                        r_row_vld[act_addr] <= 1'b1;
                    end
                end
                S_SWEEP: begin
                    if (cur_vld && row_stat.hit) begin
                        if (row_op == kat_pkg::ROP_PRESS) begin
                            r_act_held[r_idx]    <= 1'b1;
                            r_act_pressed[r_idx] <= 1'b1;
                        end else if (row_op == kat_pkg::ROP_RELEASE) begin
                            r_act_held[r_idx]    <= row_stat.held_any;
                            r_act_pressed[r_idx] <= row_stat.pressed_any;
                        end
                    end
                    if (!last_row) begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Widen the flags so the low mask bits exist at any action count
    assign held_ext    = {{MW{1'b0}}, r_act_held};
    assign pressed_ext = {{MW{1'b0}}, r_act_pressed};

    // Output register: load a finished result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_held    <= held_ext[MW-1:0];
            r_out_pressed <= pressed_ext[MW-1:0];
            r_out_err     <= r_err;
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = {r_out_pressed, r_out_held};
    assign o_m_axis_tuser[0] = r_out_err;

    // An accepted transaction always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accepting a transaction");

    // The row walk never runs past the last action
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (32'(r_idx) < 32'(MAX_ACTIONS)))
        else $error("row index beyond the action count");

    // A pressed action is always also held
    a_pressed_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_act_pressed & ~r_act_held) == '0))
        else $error("action pressed without being held");

endmodule
